>>> src/segment_tree_range_max_assert.svh
// segment_tree_range_max_assert.svh
// Assertion macros for the range-max tree; no dependencies.
`ifndef SEGMENT_TREE_RANGE_MAX_ASSERT_SVH
`define SEGMENT_TREE_RANGE_MAX_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STM_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STM_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/stm_pkg.sv
// stm_pkg.sv
// Shared widths, types and codes for the range-max tree; no dependencies.
`default_nettype none

package stm_pkg;
  localparam int VAL_W = 31;
  localparam int IDX_W = 10;
  localparam int LC_W  = 11;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LC_W-1:0]  lc_t;
  typedef logic [0:0]       func_t;

  localparam func_t FUNC_UPDATE = 1'b0;
  localparam func_t FUNC_QUERY  = 1'b1;

  localparam lc_t LC_RESET = 11'd1024;
endpackage

`default_nettype wire

>>> src/stm_in_if.sv
// stm_in_if.sv
// Input channel: valid/ready plus one operation. Depends on stm_pkg.
`default_nettype none

interface stm_in_if;
  logic              valid;
  logic              ready;
  stm_pkg::func_t    func;
  stm_pkg::idx_t     index_a;
  stm_pkg::val_t     operand_b;

  modport source (output valid, func, index_a, operand_b, input ready);
  modport sink   (input valid, func, index_a, operand_b, output ready);
endinterface

`default_nettype wire

>>> src/stm_out_if.sv
// stm_out_if.sv
// Result channel: valid/ready plus the query maximum. Depends on stm_pkg.
`default_nettype none

interface stm_out_if;
  logic          valid;
  logic          ready;
  stm_pkg::val_t range_max;

  modport source (output valid, range_max, input ready);
  modport sink   (input valid, range_max, output ready);
endinterface

`default_nettype wire

>>> src/stm_max_unit.sv
// stm_max_unit.sv
// Shared compare/select unit: larger of two node values. Depends on stm_pkg.
`default_nettype none

module stm_max_unit (
  input  stm_pkg::val_t lhs,
  input  stm_pkg::val_t rhs,
  output stm_pkg::val_t max_val
);
  assign max_val = (lhs > rhs) ? lhs : rhs;
endmodule

`default_nettype wire

>>> src/stm_node_ram.sv
// stm_node_ram.sv
// Single-port node store, one access per cycle, registered read data.
// Depends on stm_pkg.
`default_nettype none

module stm_node_ram #(
  parameter  int DEPTH = 2048,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  stm_pkg::val_t wdata,
  output stm_pkg::val_t rdata_r
);
  stm_pkg::val_t mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end
endmodule

`default_nettype wire

>>> src/stm_ctrl.sv
// stm_ctrl.sv
// Sequencer: clear pass, leaf update walk and range query walk.
// Depends on stm_pkg, stm_in_if, stm_out_if and stm_max_unit.
`default_nettype none

module stm_ctrl #(
  parameter  int CAPACITY   = 1024,
  localparam int NODE_COUNT = 2 * CAPACITY,
  localparam int NW         = $clog2(NODE_COUNT)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [NW-1:0] leaf_n,
  stm_in_if.sink        in_ch,
  stm_out_if.source     out_ch,
  output logic          mem_en,
  output logic          mem_we,
  output logic [NW-1:0] mem_addr,
  output stm_pkg::val_t mem_wdata,
  input  stm_pkg::val_t mem_rdata
);
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_SETUP = 4'd2;
  localparam logic [3:0] ST_UP_RD = 4'd3;
  localparam logic [3:0] ST_UP_WR = 4'd4;
  localparam logic [3:0] ST_Q_TST = 4'd5;
  localparam logic [3:0] ST_Q_LO  = 4'd6;
  localparam logic [3:0] ST_Q_HI  = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  localparam logic [NW-1:0] LAST_NODE = NW'(NODE_COUNT - 1);
  localparam logic [NW-1:0] ROOT_NODE = NW'(1);
  localparam logic [NW-1:0] ONE_N     = NW'(1);

  logic [3:0]     state_r, state_nxt;
  logic [NW-1:0]  ptr_r, ptr_nxt;     // clear counter, update node, query low end
  logic [NW-1:0]  hi_r, hi_nxt;       // query high end
  stm_pkg::val_t  acc_r, acc_nxt;     // carried node value / running maximum
  stm_pkg::func_t func_r;
  stm_pkg::idx_t  a_r;
  stm_pkg::val_t  b_r;
  logic           out_valid_r, out_valid_nxt;
  stm_pkg::val_t  out_data_r, out_data_nxt;

  stm_pkg::val_t  max_val;
  logic [31:0]    n_w, a_w, b_w, bc_w, lo_w, hi_w;
  logic           q_empty, up_drop;
  logic [NW:0]    lo_inc;
  logic [NW-1:0]  hi_dec;
  logic [NW-1:0]  parent;

  stm_max_unit u_max (
    .lhs     (acc_r),
    .rhs     (mem_rdata),
    .max_val (max_val)
  );

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.range_max = out_data_r;

  // start-of-item bounds, all in 32-bit space
  always_comb begin
    n_w     = 32'(leaf_n);
    a_w     = 32'(a_r);
    b_w     = 32'(b_r);
    bc_w    = (b_w >= n_w) ? (n_w - 32'd1) : b_w;
    q_empty = (a_w > bc_w);
    up_drop = (a_w >= n_w);
    lo_w    = a_w + n_w;
    hi_w    = bc_w + n_w;
  end

  assign lo_inc = {1'b0, ptr_r} + {{NW{1'b0}}, 1'b1};
  assign hi_dec = hi_r - ONE_N;
  assign parent = {1'b0, ptr_r[NW-1:1]};

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    hi_nxt        = hi_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_data_nxt  = out_data_r;
    mem_en        = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = ptr_r;
    mem_wdata     = acc_r;

    unique case (state_r)
      ST_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_wdata = '0;
        ptr_nxt   = ptr_r + ONE_N;
        if (ptr_r == LAST_NODE) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        unique case (func_r)
          stm_pkg::FUNC_UPDATE: begin
            if (up_drop) begin
              state_nxt = ST_IDLE;
            end else begin
              // write the leaf, then walk toward the root
              mem_en    = 1'b1;
              mem_we    = 1'b1;
              mem_addr  = lo_w[NW-1:0];
              mem_wdata = b_r;
              acc_nxt   = b_r;
              ptr_nxt   = lo_w[NW-1:0];
              state_nxt = (lo_w[NW-1:0] == ROOT_NODE) ? ST_IDLE : ST_UP_RD;
            end
          end
          stm_pkg::FUNC_QUERY: begin
            acc_nxt   = '0;
            ptr_nxt   = lo_w[NW-1:0];
            hi_nxt    = hi_w[NW-1:0];
            state_nxt = q_empty ? ST_DONE : ST_Q_TST;
          end
        endcase
      end
      ST_UP_RD: begin
        mem_en    = 1'b1;
        mem_addr  = ptr_r ^ ONE_N;
        state_nxt = ST_UP_WR;
      end
      ST_UP_WR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = parent;
        mem_wdata = max_val;
        acc_nxt   = max_val;
        ptr_nxt   = parent;
        state_nxt = (parent == ROOT_NODE) ? ST_IDLE : ST_UP_RD;
      end
      ST_Q_TST: begin
        if (ptr_r > hi_r) begin
          state_nxt = ST_DONE;
        end else if (ptr_r[0]) begin
          mem_en    = 1'b1;
          state_nxt = ST_Q_LO;
        end else if (!hi_r[0]) begin
          mem_en    = 1'b1;
          mem_addr  = hi_r;
          state_nxt = ST_Q_HI;
        end else begin
          ptr_nxt = parent;
          hi_nxt  = {1'b0, hi_r[NW-1:1]};
        end
      end
      ST_Q_LO: begin
        acc_nxt = max_val;
        if (!hi_r[0]) begin
          // low end does not pass the high end here, no carry out
          ptr_nxt   = lo_inc[NW-1:0];
          mem_en    = 1'b1;
          mem_addr  = hi_r;
          state_nxt = ST_Q_HI;
        end else begin
          ptr_nxt   = lo_inc[NW:1];
          hi_nxt    = {1'b0, hi_r[NW-1:1]};
          state_nxt = ST_Q_TST;
        end
      end
      ST_Q_HI: begin
        acc_nxt   = max_val;
        ptr_nxt   = parent;
        hi_nxt    = {1'b0, hi_dec[NW-1:1]};
        state_nxt = ST_Q_TST;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r       <= hi_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
    if (in_ch.valid && in_ch.ready) begin
      func_r <= in_ch.func;
      a_r    <= in_ch.index_a;
      b_r    <= in_ch.operand_b;
    end
  end
endmodule

`default_nettype wire

>>> src/segment_tree_range_max.sv
// Range-maximum segment tree over up to CAPACITY leaves, bottom-up layout
// (leaf i at node leaf_count + i, node k = max of nodes 2k and 2k+1). Each
// input transfer is a point update (func 0: leaf index_a gets operand_b, no
// result) or an inclusive range query (func 1: one result transfer with the
// maximum over leaves index_a..operand_b, 0 for an empty range). The node
// store is a single-port RAM of 2*CAPACITY words, so the walks share its one
// port: an update writes the leaf, then reads the sibling and writes the
// parent at each level up to the root; a dropped update (index_a past the
// leaf count) touches no word. A query reads the nodes that cover its range
// level by level, and its result waits while an earlier result still sits
// in the output register. One item is in flight at a time; a finished query
// result sits in an output register, so the next item is taken while it
// waits. After reset all 2*CAPACITY words are swept to zero, one word per
// cycle, with in ready low throughout the sweep (cfg writes still land).
// Depends on stm_pkg, stm_in_if, stm_out_if, stm_node_ram, stm_ctrl and the
// assertion macro header.
`default_nettype none
`include "segment_tree_range_max_assert.svh"

module segment_tree_range_max #(
  parameter int CAPACITY = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  stm_pkg::lc_t  cfg_wdata,
  stm_in_if.sink        in_ch,
  stm_out_if.source     out_ch
);
  localparam int NODE_COUNT = 2 * CAPACITY;
  localparam int NW         = $clog2(NODE_COUNT);
  localparam int NWP        = NW + 1;
  localparam logic [NW:0] NODE_COUNT_W = NWP'(NODE_COUNT);

  stm_pkg::lc_t  leaf_count_r;
  logic [31:0]   lc_w, n_w;
  logic [NW-1:0] leaf_n;

  logic          mem_en;
  logic          mem_we;
  logic [NW-1:0] mem_addr;
  stm_pkg::val_t mem_wdata;
  stm_pkg::val_t mem_rdata;

  logic          in_xfer;
  logic          addr_ok;

  // leaf count register; the layout follows it with no clearing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_count_r <= stm_pkg::LC_RESET;
    end else if (cfg_we) begin
      leaf_count_r <= cfg_wdata;
    end
  end

  // effective leaf count: zero reads as one, above CAPACITY clamps
  always_comb begin
    lc_w = 32'(leaf_count_r);
    if (lc_w == 32'd0) begin
      n_w = 32'd1;
    end else if (lc_w > 32'(CAPACITY)) begin
      n_w = 32'(CAPACITY);
    end else begin
      n_w = lc_w;
    end
  end
  assign leaf_n = n_w[NW-1:0];

  stm_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .leaf_n    (leaf_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  stm_node_ram #(
    .DEPTH (NODE_COUNT)
  ) u_ram (
    .clk     (clk),
    .en      (mem_en),
    .we      (mem_we),
    .addr    (mem_addr),
    .wdata   (mem_wdata),
    .rdata_r (mem_rdata)
  );

  assign in_xfer = in_ch.valid && in_ch.ready;
  assign addr_ok = ({1'b0, mem_addr} < NODE_COUNT_W);

  // sequencer never touches the store while waiting for work
  `STM_ASSERT_IMP(a_idle_no_mem, clk, rst_n, in_ch.ready, !mem_en, "RAM access while idle")
  // every store access stays inside the node range
  `STM_ASSERT_IMP(a_addr_range, clk, rst_n, mem_en, addr_ok, "node address out of range")
  // ready always drops once a transfer is accepted
  `STM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_xfer, !in_ch.ready, "ready after accept")
  // clear sweep holds off input right after reset
  `STM_ASSERT_IMP(a_clear_after_reset, clk, rst_n, !$past(rst_n), !in_ch.ready, "ready in clear")
endmodule

`default_nettype wire

>>> verif/segment_tree_range_max_tb.sv
`timescale 1ns / 100ps
// segment_tree_range_max_tb.sv
// Self-checking bench for segment_tree_range_max with its own tree predictor and
// bursty random traffic. Depends on stm_pkg, stm_in_if, stm_out_if and the RTL.

module segment_tree_range_max_tb;

  localparam int CAPACITY = 1024;
  localparam int NODES = 2 * CAPACITY;
  // An update walks to the root with no result, so give the block this long
  // before touching leaf_count.
  localparam int DRAIN_CYCLES = 64;
  // The post-reset clearing sweep alone writes 2*CAPACITY words with no transfer.
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_PER_PHASE = 115;
  localparam stm_pkg::val_t VAL_MAX = '1;

  typedef struct packed {
    stm_pkg::func_t func;
    stm_pkg::idx_t  index_a;
    stm_pkg::val_t  operand_b;
  } tree_op_t;

  // Result-side ready patterns.
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_COMB, RX_LONG} rx_mode_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  stm_pkg::lc_t cfg_wdata;

  stm_in_if  in_if ();
  stm_out_if out_if ();

  segment_tree_range_max #(.CAPACITY(CAPACITY)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor: private copy of the node store and of leaf_count.
  // ---------------------------------------------------------------------------
  stm_pkg::val_t tree_model [NODES];
  stm_pkg::lc_t  leaf_cfg;
  stm_pkg::val_t expected_max_q [$];   // one entry per accepted query
  tree_op_t      op_q [$];             // operations not yet on the bus
  int unsigned   ops_queued;
  int unsigned   ops_taken;
  int unsigned   error_count;

  // Zero and oversized leaf counts fold into 1..CAPACITY.
  function automatic int unsigned leaves_in_use();
    int unsigned n;
    n = 32'(leaf_cfg);
    if (n == 0) n = 1;
    if (n > CAPACITY) n = CAPACITY;
    return n;
  endfunction

  function automatic stm_pkg::val_t node_at(int unsigned k);
    return (k < NODES) ? tree_model[k] : '0;
  endfunction

  function automatic stm_pkg::val_t max2(stm_pkg::val_t x, stm_pkg::val_t y);
    return (x > y) ? x : y;
  endfunction

  // Applies one accepted transfer to the model; queries queue their maximum.
  function automatic void apply_tree_op(tree_op_t op);
    int unsigned   n;
    int unsigned   a;
    int unsigned   b;
    int unsigned   k;
    int unsigned   lo;
    int unsigned   hi;
    int unsigned   top;
    stm_pkg::val_t best;
    n = leaves_in_use();
    a = 32'(op.index_a);
    b = 32'(op.operand_b);
    if (op.func == stm_pkg::FUNC_UPDATE) begin
      // Leaf past the active count: silently dropped.
      if (a < n) begin
        k = n + a;
        tree_model[k] = op.operand_b;
        for (k = k >> 1; k >= 1; k = k >> 1)
          tree_model[k] = max2(node_at(2 * k), node_at(2 * k + 1));
      end
    end else begin
      best = '0;
      top = (b >= n) ? n - 1 : b;  // clamp high end
      if (a <= top) begin
        lo = a + n;
        hi = top + n;
        while (lo <= hi) begin
          if (lo[0]) begin
            best = max2(best, node_at(lo));
            lo++;
          end
          if (!hi[0] && lo <= hi + 1) begin
            best = max2(best, node_at(hi));
            hi--;
          end
          lo = lo >> 1;
          hi = hi >> 1;
        end
      end
      expected_max_q = {expected_max_q, best};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_op(stm_pkg::func_t f, int unsigned a, stm_pkg::val_t b);
    tree_op_t op;
    op.func = f;
    op.index_a = stm_pkg::idx_t'(a);
    op.operand_b = b;
    op_q = {op_q, op};
    ops_queued++;
  endfunction

  // Mix of extremes, tiny values (lots of ties) and full-width noise.
  function automatic stm_pkg::val_t rand_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return VAL_MAX;
      2: return stm_pkg::val_t'($urandom_range(0, 15));
      default: return stm_pkg::val_t'($urandom);
    endcase
  endfunction

  // Mostly in-range indices for the current leaf count; a tenth anywhere in the
  // index field, so updates get dropped and queries go empty now and then.
  function automatic void queue_random_op(int unsigned n);
    stm_pkg::func_t f;
    int unsigned    a;
    stm_pkg::val_t  b;
    f = ($urandom_range(0, 99) < 55) ? stm_pkg::FUNC_UPDATE : stm_pkg::FUNC_QUERY;
    a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, CAPACITY - 1)
                                    : $urandom_range(0, n - 1);
    if (f == stm_pkg::FUNC_UPDATE) begin
      b = rand_value();
    end else begin
      case ($urandom_range(0, 9))
        0: b = stm_pkg::val_t'($urandom);                        // far past the end
        1: b = stm_pkg::val_t'($urandom_range(0, CAPACITY - 1)); // often empty
        2: b = stm_pkg::val_t'(a);                               // single leaf
        default: b = stm_pkg::val_t'($urandom_range(a, n - 1));
      endcase
    end
    queue_op(f, a, b);
  endfunction

  // Edges of the current layout: dropped update (below full capacity), clamped and empty queries.
  function automatic void queue_layout_edges(int unsigned n);
    queue_op(stm_pkg::FUNC_UPDATE, (n < CAPACITY) ? n : n - 1, VAL_MAX);
    queue_op(stm_pkg::FUNC_QUERY, 0, VAL_MAX);
    queue_op(stm_pkg::FUNC_UPDATE, n - 1, rand_value());
    queue_op(stm_pkg::FUNC_QUERY, n - 1, stm_pkg::val_t'(n - 1));
    queue_op(stm_pkg::FUNC_QUERY, CAPACITY - 1, '0);
    queue_op(stm_pkg::FUNC_QUERY, n - 1, VAL_MAX);
  endfunction

  // Waits until every operation went out and every result came back, then
  // lets a trailing update finish its walk to the root.
  task automatic wait_idle();
    while (ops_taken != ops_queued || expected_max_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_leaf_count(stm_pkg::lc_t value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    leaf_cfg = value;
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    stm_pkg::lc_t cfg_plan [$];
    int unsigned  n;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.func = stm_pkg::FUNC_UPDATE;
    in_if.index_a = '0;
    in_if.operand_b = '0;
    out_if.ready = 1'b0;
    leaf_cfg = stm_pkg::LC_RESET;
    foreach (tree_model[i]) tree_model[i] = '0;
    ops_queued = 0;
    ops_taken = 0;
    error_count = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset layout, 1024 leaves. The first query sees the freshly cleared store.
    queue_op(stm_pkg::FUNC_QUERY, 0, stm_pkg::val_t'(CAPACITY - 1));
    queue_op(stm_pkg::FUNC_UPDATE, 0, VAL_MAX);
    queue_op(stm_pkg::FUNC_UPDATE, CAPACITY - 1, 31'h2AAAAAAA);
    queue_op(stm_pkg::FUNC_UPDATE, 512, 31'h55555555);
    queue_op(stm_pkg::FUNC_QUERY, 0, '0);
    queue_op(stm_pkg::FUNC_QUERY, 1, stm_pkg::val_t'(CAPACITY - 2));
    queue_op(stm_pkg::FUNC_QUERY, CAPACITY - 1, stm_pkg::val_t'(CAPACITY - 1));
    queue_op(stm_pkg::FUNC_QUERY, 600, VAL_MAX);           // high end clamped
    queue_op(stm_pkg::FUNC_QUERY, 700, 31'd5);             // low above high
    queue_op(stm_pkg::FUNC_QUERY, CAPACITY - 1, '0);
    queue_op(stm_pkg::FUNC_UPDATE, 0, '0);                 // lowering a max re-walks up
    queue_op(stm_pkg::FUNC_QUERY, 0, stm_pkg::val_t'(CAPACITY - 1));
    queue_op(stm_pkg::FUNC_UPDATE, 1, 31'd1);
    queue_op(stm_pkg::FUNC_QUERY, 0, 31'd1);
    queue_op(stm_pkg::FUNC_UPDATE, 513, VAL_MAX);          // sibling of the 512 leaf
    queue_op(stm_pkg::FUNC_QUERY, 512, 31'd513);
    queue_op(stm_pkg::FUNC_QUERY, 2, 31'd511);
    repeat (RANDOM_PER_PHASE) queue_random_op(CAPACITY);

    // Leaf count zero and above capacity both fold; the store is never cleared
    // between layouts, so each phase reads what the last one left behind.
    cfg_plan = '{11'd1, 11'd0, 11'd2, 11'd3, 11'd1025, 11'd2047, 11'd7,
                 11'd1024, 11'd64, 11'd513};
    cfg_plan = {cfg_plan, stm_pkg::lc_t'($urandom_range(1, 2047))};
    foreach (cfg_plan[p]) begin
      wait_idle();
      write_leaf_count(cfg_plan[p]);
      n = leaves_in_use();
      queue_layout_edges(n);
      repeat (RANDOM_PER_PHASE) queue_random_op(n);
    end

    wait_idle();
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of back-to-back operations with random gaps. The payload
  // holds while valid is up and ready is low; the model is updated at the
  // accepting edge so it always sees the layout in force.
  // ---------------------------------------------------------------------------
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk) begin
    tree_op_t op;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        apply_tree_op({in_if.func, in_if.index_a, in_if.operand_b});
        ops_taken++;
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (op_q.size() != 0) begin
          op = op_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.func <= op.func;
          in_if.index_a <= op.index_a;
          in_if.operand_b <= op.operand_b;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            // a third of bursts run straight into the next one
            burst_left = $urandom_range(0, 31);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every result transfer against the oldest expected maximum
  // and paces ready with a pattern that is picked at random from four modes.
  // ---------------------------------------------------------------------------
  int unsigned rx_tick;
  rx_mode_t    rx_mode;

  always @(posedge clk) begin
    stm_pkg::val_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_tick = 0;
      rx_mode = RX_OPEN;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_max_q.size() == 0) begin
          error_count++;
          $error("range_max: expected none, got %0d", out_if.range_max);
        end else begin
          want = expected_max_q.pop_front();
          if (out_if.range_max !== want) begin
            error_count++;
            $error("range_max: expected %0d, got %0d", want, out_if.range_max);
          end
        end
      end
      rx_tick++;
      if (rx_tick[7:0] == 8'd0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:   out_if.ready <= 1'b1;
        RX_RANDOM: out_if.ready <= 1'($urandom_range(0, 1));
        RX_COMB:   out_if.ready <= (rx_tick[2:0] != 3'd0);
        default:   out_if.ready <= (rx_tick[5:0] >= 6'd34);  // stalled while tick bits [5:0] are below 34
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transfer on either channel.
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
